FILE: rtl/rc4_pkg.sv
// ----------------------------------------------------------------------------
// RC4 cipher package
// Shared constants, datapath commands and controller/datapath status types.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int BYTE_W     = 8;
  localparam int PERM_DEPTH = 256;
  localparam int DROP_W     = 12;

  // Last step index of the key schedule.
  localparam logic [BYTE_W-1:0] KSA_LAST = BYTE_W'(PERM_DEPTH - 1);

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_KEY_WR,
    CMD_INIT,
    CMD_KSA_RD,
    CMD_KSA_J,
    CMD_KSA_WK,
    CMD_CLR_IDX,
    CMD_KS_RD,
    CMD_KS_J,
    CMD_KS_WI
  } cmd_e;

  typedef struct packed {
    cmd_e op;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic room;
  } dp_status_t;

endpackage

FILE: rtl/rc4_ram.sv
// ----------------------------------------------------------------------------
// RC4 generic RAM
// One write port and one read port, read data registered, read-before-write.
// ----------------------------------------------------------------------------
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/rc4_ctrl.sv
// ----------------------------------------------------------------------------
// RC4 controller
// Sequences key writes, the key schedule, the keystream drop and data bytes.
// ----------------------------------------------------------------------------
module rc4_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      in_op_i,
  input  logic                      in_last_i,
  input  logic                      cfg_wr_en_i,
  input  logic [rc4_pkg::DROP_W-1:0] cfg_wr_data_i,
  input  rc4_pkg::dp_status_t       status_i,
  output rc4_pkg::ctrl_cmd_t        cmd_o
);
  import rc4_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_KSA_RD,
    ST_KSA_J,
    ST_KSA_WK,
    ST_SCHED_END,
    ST_KS_RD,
    ST_KS_J,
    ST_KS_WI
  } state_e;

  state_e            state_q;
  logic [DROP_W-1:0] step_q;
  logic [DROP_W-1:0] drop_q;
  logic              drop_mode_q;
  logic              accept;

  assign in_ready_o = (state_q == ST_IDLE) && status_i.room;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.emit = !drop_mode_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.op = in_op_i ? CMD_KS_RD : CMD_KEY_WR;
        end else begin
          cmd_o.op = CMD_NOP;
        end
      end
      ST_INIT:      cmd_o.op = CMD_INIT;
      ST_KSA_RD:    cmd_o.op = CMD_KSA_RD;
      ST_KSA_J:     cmd_o.op = CMD_KSA_J;
      ST_KSA_WK:    cmd_o.op = CMD_KSA_WK;
      ST_SCHED_END: cmd_o.op = CMD_CLR_IDX;
      ST_KS_RD:     cmd_o.op = CMD_KS_RD;
      ST_KS_J:      cmd_o.op = CMD_KS_J;
      ST_KS_WI:     cmd_o.op = CMD_KS_WI;
      default:      cmd_o.op = CMD_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      drop_q      <= '0;
      drop_mode_q <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        drop_q <= cfg_wr_data_i;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (in_op_i) begin
              drop_mode_q <= 1'b0;
              state_q     <= ST_KS_J;
            end else if (in_last_i) begin
              state_q <= ST_INIT;
            end
          end
        end
        ST_INIT: begin
          step_q  <= '0;
          state_q <= ST_KSA_RD;
        end
        ST_KSA_RD: state_q <= ST_KSA_J;
        ST_KSA_J:  state_q <= ST_KSA_WK;
        ST_KSA_WK: begin
          if (step_q[BYTE_W-1:0] == KSA_LAST) begin
            state_q <= ST_SCHED_END;
          end else begin
            step_q  <= step_q + DROP_W'(1);
            state_q <= ST_KSA_RD;
          end
        end
        ST_SCHED_END: begin
          step_q      <= '0;
          drop_mode_q <= 1'b1;
          state_q     <= (drop_q == '0) ? ST_IDLE : ST_KS_RD;
        end
        ST_KS_RD: state_q <= ST_KS_J;
        ST_KS_J:  state_q <= ST_KS_WI;
        ST_KS_WI: begin
          if (drop_mode_q && (step_q != drop_q - DROP_W'(1))) begin
            step_q  <= step_q + DROP_W'(1);
            state_q <= ST_KS_RD;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/rc4_dp.sv
// ----------------------------------------------------------------------------
// RC4 datapath
// Permutation and key store RAMs, indices, swap write-back and output queue.
// ----------------------------------------------------------------------------
module rc4_dp #(
  parameter int KEY_DEPTH = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rc4_pkg::ctrl_cmd_t        cmd_i,
  output rc4_pkg::dp_status_t       status_o,
  input  logic [rc4_pkg::BYTE_W-1:0] value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [rc4_pkg::BYTE_W-1:0] out_data_o
);
  import rc4_pkg::*;

  localparam int KAW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int KCW = $clog2(KEY_DEPTH + 1);

  // Permutation RAM ports
  logic              p_we;
  logic [BYTE_W-1:0] p_waddr, p_wdata, p_raddr, p_rdata;
  // Read-result qualifiers: entries not yet written read as their index
  logic [PERM_DEPTH-1:0] vld_q;
  logic              vld_rd_q, fwd_q;
  logic [BYTE_W-1:0] fwd_data_q, raddr_q, s_rd;

  logic [BYTE_W-1:0] i_q, j_q, k_q, a_q, value_q, j_sum;
  logic [BYTE_W-1:0] pw_addr_q, pw_data_q;
  logic              pend_q, emit_q, tj_q;
  logic [KAW-1:0]    kidx_q;
  logic [KCW-1:0]    key_cnt_q, key_len_q;
  logic              k_we;
  logic [BYTE_W-1:0] k_rdata;

  logic [BYTE_W-1:0] fifo_q [2];
  logic              wptr_q, rptr_q;
  logic [1:0]        fifo_cnt_q;
  logic              push, pop;
  logic [BYTE_W-1:0] result;

  rc4_ram #(.WIDTH(BYTE_W), .DEPTH(PERM_DEPTH)) u_perm_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  assign k_we = (cmd_i.op == CMD_KEY_WR) && (key_cnt_q < KCW'(KEY_DEPTH));

  rc4_ram #(.WIDTH(BYTE_W), .DEPTH(KEY_DEPTH)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (k_we),
    .waddr_i (key_cnt_q[KAW-1:0]),
    .wdata_i (value_i),
    .raddr_i (kidx_q),
    .rdata_o (k_rdata)
  );

  assign s_rd  = fwd_q ? fwd_data_q : (vld_rd_q ? p_rdata : raddr_q);
  assign j_sum = j_q + s_rd + ((cmd_i.op == CMD_KSA_J) ? k_rdata : '0);

  always_comb begin
    p_we    = pend_q;
    p_waddr = pw_addr_q;
    p_wdata = pw_data_q;
    p_raddr = i_q + BYTE_W'(1);
    case (cmd_i.op)
      CMD_KSA_RD: p_raddr = k_q;
      CMD_KSA_J:  p_raddr = j_sum;
      CMD_KSA_WK: begin
        p_we    = 1'b1;
        p_waddr = k_q;
        p_wdata = s_rd;
      end
      CMD_KS_J:   p_raddr = j_sum;
      CMD_KS_WI: begin
        p_we    = 1'b1;
        p_waddr = i_q;
        p_wdata = s_rd;
        p_raddr = a_q + s_rd;
      end
      default: ;
    endcase
  end

  // Output lookup: if it hit the pending swap slot, take the value bound for it
  assign result = value_q ^ (tj_q ? a_q : s_rd);
  assign push   = pend_q && emit_q;
  assign pop    = out_valid_o && out_ready_i;

  assign out_valid_o   = (fifo_cnt_q != 2'd0);
  assign out_data_o    = fifo_q[rptr_q];
  assign status_o.room = (fifo_cnt_q == 2'd0) || ((fifo_cnt_q == 2'd1) && !push);

  always_ff @(posedge clk_i) begin
    fwd_data_q <= p_wdata;
    raddr_q    <= p_raddr;
    case (cmd_i.op)
      CMD_KSA_J, CMD_KS_J: a_q <= s_rd;
      CMD_KSA_WK: begin
        pw_addr_q <= j_q;
        pw_data_q <= a_q;
      end
      CMD_KS_RD: value_q <= value_i;
      CMD_KS_WI: begin
        pw_addr_q <= j_q;
        pw_data_q <= a_q;
        tj_q      <= (p_raddr == j_q);
      end
      default: ;
    endcase
    if (push) begin
      fifo_q[wptr_q] <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      vld_rd_q   <= 1'b0;
      fwd_q      <= 1'b0;
      i_q        <= '0;
      j_q        <= '0;
      k_q        <= '0;
      kidx_q     <= '0;
      key_cnt_q  <= '0;
      key_len_q  <= '0;
      pend_q     <= 1'b0;
      emit_q     <= 1'b0;
      wptr_q     <= 1'b0;
      rptr_q     <= 1'b0;
      fifo_cnt_q <= '0;
    end else begin
      vld_rd_q <= vld_q[p_raddr];
      fwd_q    <= p_we && (p_waddr == p_raddr);
      // Defer the second swap write to the next cycle
      pend_q   <= (cmd_i.op == CMD_KSA_WK) || (cmd_i.op == CMD_KS_WI);
      if (cmd_i.op == CMD_INIT) begin
        vld_q <= '0;
      end else if (p_we) begin
        vld_q[p_waddr] <= 1'b1;
      end
      case (cmd_i.op)
        CMD_KEY_WR: begin
          if (k_we) begin
            key_cnt_q <= key_cnt_q + KCW'(1);
          end
        end
        CMD_INIT: begin
          key_len_q <= key_cnt_q;
          key_cnt_q <= '0;
          k_q       <= '0;
          kidx_q    <= '0;
          i_q       <= '0;
          j_q       <= '0;
        end
        CMD_KSA_J: j_q <= j_sum;
        CMD_KSA_WK: begin
          k_q    <= k_q + BYTE_W'(1);
          emit_q <= 1'b0;
          // Cycle the key over its stored length
          if (KCW'(kidx_q) == key_len_q - KCW'(1)) begin
            kidx_q <= '0;
          end else begin
            kidx_q <= kidx_q + KAW'(1);
          end
        end
        CMD_CLR_IDX: begin
          i_q <= '0;
          j_q <= '0;
        end
        CMD_KS_RD: i_q <= i_q + BYTE_W'(1);
        CMD_KS_J:  j_q <= j_sum;
        CMD_KS_WI: begin
          emit_q <= cmd_i.emit;
        end
        default: ;
      endcase
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
      fifo_cnt_q <= fifo_cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // The deferred swap write must never collide with a commanded write
  a_pend_no_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !(cmd_i.op == CMD_KSA_WK || cmd_i.op == CMD_KS_WI))
    else $error("pending swap write collides with a commanded write");

  a_fifo_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (fifo_cnt_q != 2'd2 || pop))
    else $error("output queue overflow");

  a_key_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_cnt_q <= KCW'(KEY_DEPTH))
    else $error("key count beyond key store depth");

endmodule

FILE: rtl/rc4_keystream_cipher_top.sv
// ----------------------------------------------------------------------------
// RC4 keystream cipher, top level
// RC4-drop-N byte cipher with key store, key schedule and keystream drop.
// ----------------------------------------------------------------------------
// Send key bytes with tuser low; they are stored (up to KEY_DEPTH, the rest
// dropped) and give no output word. The key byte with tlast high re-keys:
// the permutation returns to identity, the 256-step key schedule runs over
// the stored key, i and j clear and cfg drop_count keystream bytes are
// discarded; the input stalls meanwhile. Data bytes (tuser high) come back
// XORed with the next keystream byte; a data word steps through accept and
// read S[i], read S[j], then swap and read the output entry, set by the three
// dependent lookups through the single registered read port of the
// permutation RAM.
// The result shows up in a two-word output queue, so input keeps flowing
// while a result waits. Write drop_count only while the block is idle.
// ----------------------------------------------------------------------------
module rc4_keystream_cipher_top #(
  parameter int KEY_DEPTH = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Input stream
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [rc4_pkg::BYTE_W-1:0] s_axis_tdata_i,  // [7:0] value
  input  logic                      s_axis_tuser_i,  // [0] operation
  input  logic                      s_axis_tlast_i,  // last key byte
  // Output stream
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [rc4_pkg::BYTE_W-1:0] m_axis_tdata_o,  // [7:0] result_byte
  // Configuration: drop_count
  input  logic                      cfg_wr_en_i,
  input  logic [rc4_pkg::DROP_W-1:0] cfg_wr_data_i
);
  import rc4_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequence schedule, drop and data steps
  rc4_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .in_op_i       (s_axis_tuser_i),
    .in_last_i     (s_axis_tlast_i),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  // Hold permutation, key and indices; queue results
  rc4_dp #(.KEY_DEPTH(KEY_DEPTH)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .value_i     (s_axis_tdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule
